// ===== src/te2f_pkg.sv =====
package te2f_pkg;

  typedef enum logic [2:0] {
    ET_FP32  = 3'd0,
    ET_FP16  = 3'd1,
    ET_INT8  = 3'd2,
    ET_INT32 = 3'd3,
    ET_BOOL  = 3'd4,
    ET_UINT8 = 3'd5
  } elem_type_e;

  localparam logic [31:0] SignBit32 = 32'h8000_0000;
  localparam logic [31:0] OneF32    = 32'h3F80_0000;
  localparam logic [7:0]  ExpInfNan = 8'hFF;

  // Position of the highest set bit; 0 when the value is zero.
  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// ===== src/te2f_mag_cvt.sv =====
// Unsigned 32-bit magnitude to single float, round to nearest even.
module te2f_mag_cvt (
  input  logic [31:0] mag_i,
  output logic [31:0] float_o
);
  logic [4:0]  p;
  logic [4:0]  sh;
  logic [31:0] norm;
  logic [31:0] lowmask;
  logic [31:0] rem;
  logic [31:0] half;
  logic [24:0] mant;
  logic        rnd_up;

  always_comb begin
    p       = te2f_pkg::msb_pos(mag_i);
    sh      = (p > 5'd23) ? 5'(p - 5'd23) : 5'd0;
    norm    = (p <= 5'd23) ? (mag_i << (5'd23 - p)) : (mag_i >> sh);
    lowmask = (32'd1 << sh) - 32'd1;
    rem     = mag_i & lowmask;
    half    = (sh == 5'd0) ? 32'd0 : (32'd1 << (sh - 5'd1));
    rnd_up  = (sh != 5'd0) && ((rem > half) || ((rem == half) && norm[0]));
    mant    = {1'b0, norm[23:0]} + {24'd0, rnd_up};
    // a carry into bit 24 bumps the exponent through the add
    if (mag_i == 32'd0) begin
      float_o = '0;
    end else begin
      float_o = {1'b0, 8'(p) + 8'd127, 23'd0} + {7'd0, mant} - 32'h0080_0000;
    end
  end
endmodule

// ===== src/te2f_label.sv =====
// Float bits to byte label: round half away from zero, saturate, NaN and negatives to 0.
module te2f_label (
  input  logic [31:0] float_i,
  output logic [7:0]  label_o
);
  logic [7:0]  e;
  logic [23:0] sig;
  logic [4:0]  sh;
  logic [8:0]  twice;
  logic [8:0]  r;

  always_comb begin
    e     = float_i[30:23];
    sig   = {1'b1, float_i[22:0]};
    sh    = 5'(8'd149 - e);
    twice = 9'(sig >> sh);
    r     = 9'((10'(twice) + 10'd1) >> 1);
    if (e == te2f_pkg::ExpInfNan && float_i[22:0] != '0) label_o = '0;
    else if (float_i[31])                                label_o = '0;
    else if (e >= 8'd135)                                label_o = 8'hFF;
    else if (e < 8'd126)                                 label_o = '0;
    else if (r > 9'd255)                                 label_o = 8'hFF;
    else                                                 label_o = r[7:0];
  end
endmodule

// ===== src/tensor_element_to_fp32_top.sv =====
// Pipeline: the accepting edge loads the input registers, which feed the result registers and strobe.
// Throughput: one element per cycle; busy_o is always low and start_i is taken every cycle.
// Reset: element_type returns to fp32, pipeline valids clear; payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module tensor_element_to_fp32_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] raw_bits_i,
  output logic        done_o,
  output logic [31:0] fp32_bits_o,
  output logic [7:0]  label_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [2:0]  etype_q;
  logic        in_vld_q;
  logic [31:0] raw_q;
  logic [2:0]  et_q;
  logic        out_vld_q;
  logic [31:0] fb_q, fb_d;
  logic [7:0]  lab_q, lab_d;

  logic [7:0]  b;
  logic [31:0] mag;
  logic [31:0] mag_f;
  logic [31:0] hf;
  logic [31:0] lab_src;
  logic [7:0]  lab_f;
  logic [9:0]  hm;
  logic [4:0]  he;
  logic [3:0]  hp;
  logic [9:0]  hn;

  assign busy_o = 1'b0;
  assign pready = 1'b1;
  assign prdata = {29'd0, etype_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      etype_q   <= 3'(te2f_pkg::ET_FP32);
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) etype_q <= pwdata[2:0];
      in_vld_q  <= start_i;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_bits_i;
    et_q  <= etype_q;
    fb_q  <= fb_d;
    lab_q <= lab_d;
  end

  always_comb begin
    b  = raw_q[7:0];
    hm = raw_q[9:0];
    he = raw_q[14:10];
    hp = 4'(te2f_pkg::msb_pos({22'd0, hm}));
    hn = 10'(hm << (4'd10 - hp));
    if (he == 5'd0) begin
      if (hm == '0) hf = {raw_q[15], 31'd0};
      else hf = {raw_q[15], 8'(8'd103 + 8'(hp)), hn, 13'd0};
    end else if (he == 5'h1F) begin
      hf = {raw_q[15], 8'hFF, hm, 13'd0};
    end else begin
      hf = {raw_q[15], 8'(8'(he) + 8'd112), hm, 13'd0};
    end
    case (et_q)
      te2f_pkg::ET_INT8:  mag = b[7] ? {24'd0, 8'(9'h100 - {1'b0, b})} : {24'd0, b};
      te2f_pkg::ET_INT32: mag = raw_q[31] ? (32'd0 - raw_q) : raw_q;
      default:            mag = {24'd0, b};
    endcase
    lab_src = (et_q == 3'(te2f_pkg::ET_FP16)) ? hf : raw_q;
  end

  te2f_mag_cvt u_mag (.mag_i(mag), .float_o(mag_f));
  te2f_label   u_lab (.float_i(lab_src), .label_o(lab_f));

  always_comb begin
    case (et_q)
      te2f_pkg::ET_FP32: begin fb_d = raw_q; lab_d = lab_f; end
      te2f_pkg::ET_FP16: begin fb_d = hf; lab_d = lab_f; end
      te2f_pkg::ET_INT8: begin
        fb_d  = b[7] ? (te2f_pkg::SignBit32 | mag_f) : mag_f;
        lab_d = b[7] ? 8'd0 : b;
      end
      te2f_pkg::ET_INT32: begin
        fb_d  = raw_q[31] ? (te2f_pkg::SignBit32 | mag_f) : mag_f;
        lab_d = raw_q[31] ? 8'd0 : ((raw_q > 32'd255) ? 8'hFF : raw_q[7:0]);
      end
      te2f_pkg::ET_BOOL: begin
        fb_d  = (b != 0) ? te2f_pkg::OneF32 : 32'd0;
        lab_d = (b != 0) ? 8'hFF : 8'd0;
      end
      te2f_pkg::ET_UINT8: begin fb_d = mag_f; lab_d = b; end
      default: begin fb_d = '0; lab_d = '0; end
    endcase
  end

  assign done_o      = out_vld_q;
  assign fp32_bits_o = fb_q;
  assign label_o     = lab_q;

  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##2 done_o) else $error("request lost in pipeline");
  a_nostart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(start_i, 2) && $past(rst_ni, 2) |-> !done_o) else $error("spurious result");
  a_bool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(et_q) == 3'(te2f_pkg::ET_BOOL) |-> (label_o == 8'hFF) == (fp32_bits_o != 0))
    else $error("bool outputs disagree");
endmodule

// ===== verif/te2f_checker.sv =====
`timescale 1ns / 1ps

module te2f_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] raw_bits_i,
  input  logic        done_i,
  input  logic [31:0] fp32_bits_i,
  input  logic [7:0]  label_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] fbits;
    logic [7:0]  label;
  } conv_t;

  conv_t       conv_q[$];
  logic [2:0]  elem_type;

  // unsigned magnitude to single, round to nearest even
  function automatic logic [31:0] uint_to_single(input logic [31:0] mag);
    int          top;
    int          sh;
    logic [31:0] rem;
    logic [31:0] halfw;
    logic [31:0] mant;
    top = -1;
    if (mag == 0) return 32'h0;
    for (int i = 0; i < 32; i++) if (mag[i]) top = i;
    if (top <= 23) begin
      mant = mag << (23 - top);
    end else begin
      sh    = top - 23;
      rem   = mag & ((32'h1 << sh) - 1);
      halfw = 32'h1 << (sh - 1);
      mant  = mag >> sh;
      if (rem > halfw || (rem == halfw && mant[0])) mant++;
    end
    return ((32'(top) + 32'd127) << 23) + (mant - 32'h0080_0000);
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] sgn;
    int          ex;
    logic [31:0] m;
    sgn = {h[15], 31'h0};
    ex  = int'(h[14:10]);
    m   = {22'd0, h[9:0]};
    if (ex == 0) begin
      if (m == 0) return sgn;
      ex = 1;
      while (!m[10]) begin
        m  = m << 1;
        ex = ex - 1;
      end
      m = m & 32'h3FF;
      return sgn | (32'(ex + 112) << 23) | (m << 13);
    end
    if (ex == 31) return sgn | 32'h7F80_0000 | (m << 13);
    return sgn | (32'(ex + 112) << 23) | (m << 13);
  endfunction

  // round half away from zero, saturate to a byte; NaN and negatives give 0
  function automatic logic [7:0] single_to_label(input logic [31:0] f);
    logic [7:0]  ex;
    logic [31:0] sig;
    logic [31:0] r;
    ex = f[30:23];
    if (ex == 8'hFF && f[22:0] != 0) return 8'd0;
    if (f[31]) return 8'd0;
    if (ex >= 135) return 8'd255;
    if (ex < 126) return 8'd0;
    sig = {9'h1, f[22:0]};
    r   = ((sig >> (149 - ex)) + 1) >> 1;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic conv_t convert(input logic [2:0] et, input logic [31:0] raw);
    conv_t      c;
    logic [7:0] b;
    b = raw[7:0];
    c = '0;
    case (et)
      te2f_pkg::ET_FP32: begin
        c.fbits = raw;
        c.label = single_to_label(raw);
      end
      te2f_pkg::ET_FP16: begin
        c.fbits = half_to_single(raw[15:0]);
        c.label = single_to_label(c.fbits);
      end
      te2f_pkg::ET_INT8: begin
        if (b[7]) c.fbits = te2f_pkg::SignBit32 | uint_to_single(32'h100 - {24'd0, b});
        else begin
          c.fbits = uint_to_single({24'd0, b});
          c.label = b;
        end
      end
      te2f_pkg::ET_INT32: begin
        if (raw[31]) c.fbits = te2f_pkg::SignBit32 | uint_to_single(32'd0 - raw);
        else begin
          c.fbits = uint_to_single(raw);
          c.label = (raw > 255) ? 8'd255 : raw[7:0];
        end
      end
      te2f_pkg::ET_BOOL: begin
        c.fbits = (b != 0) ? te2f_pkg::OneF32 : 32'h0;
        c.label = (b != 0) ? 8'd255 : 8'd0;
      end
      te2f_pkg::ET_UINT8: begin
        c.fbits = uint_to_single({24'd0, b});
        c.label = b;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    conv_t want;
    int    errs;
    errs = 0;
    if (!rst_ni) begin
      elem_type <= te2f_pkg::ET_FP32;
      errors_o  <= 0;
      pending_o <= 0;
      conv_q.delete();
    end else begin
      if (done_i) begin
        if (conv_q.size() == 0) begin
          $display("%0t: unexpected result float=%h label=%0d", $time,
                   fp32_bits_i, label_i);
          errs++;
        end else begin
          want = conv_q.pop_front();
          if (want.fbits !== fp32_bits_i) begin
            $display("%0t: float bits expected %h actual %h", $time, want.fbits,
                     fp32_bits_i);
            errs++;
          end
          if (want.label !== label_i) begin
            $display("%0t: label expected %0d actual %0d", $time, want.label, label_i);
            errs++;
          end
        end
      end
      if (start_i && !busy_i) conv_q.insert(conv_q.size(), convert(elem_type, raw_bits_i));
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == 2'd0)
        elem_type <= pwdata_i[2:0];
      errors_o  <= errors_o + errs;
      pending_o <= conv_q.size();
    end
  end

endmodule

// ===== verif/tensor_element_to_fp32_top_tb.sv =====
`timescale 1ns / 1ps

module tensor_element_to_fp32_top_tb;

  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] raw_bits_i = '0;
  logic        done_o;
  logic [31:0] fp32_bits_o;
  logic [7:0]  label_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          cycles = 0;

  always #6 clk_i = ~clk_i;

  tensor_element_to_fp32_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .raw_bits_i, .done_o, .fp32_bits_o,
    .label_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  te2f_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .raw_bits_i, .done_i(done_o),
    .fp32_bits_i(fp32_bits_o), .label_i(label_o), .psel_i(psel),
    .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata),
    .pready_i(pready), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_type(input logic [2:0] et);
    start_i <= 1'b0;
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 2'd0;
    pwdata  <= ({$urandom} & ~32'h7) | {29'd0, et};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one request; idle gap drawn per item, with stretches of none
  task automatic send(input logic [31:0] raw, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i    <= 1'b1;
    raw_bits_i <= raw;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_raw(input logic [2:0] et);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: r = r & 32'h1FF;
      1: if (et == te2f_pkg::ET_FP32) r = {r[31], 8'($urandom_range(120, 136)), r[22:0]};
      2: if (et == te2f_pkg::ET_FP16)
           r = {r[31:16], r[15], 5'($urandom_range(12, 22)), r[9:0]};
      3: if (et == te2f_pkg::ET_FP16) r[14:10] = $urandom_range(0, 1) ? 5'h1F : 5'h0;
      4: if (et == te2f_pkg::ET_FP32) r[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h0;
      5: if (et == te2f_pkg::ET_BOOL) r[7:0] = 8'($urandom_range(0, 2));
      default: ;
    endcase
    return r;
  endfunction

  logic [31:0] directed[] = '{
    32'h0, 32'hFFFF_FFFF, 32'h3F00_0000, 32'hBECC_CCCD, 32'h437F_8000, 32'h7F80_0000,
    32'hFF80_0000, 32'h7FC0_0001, 32'h0000_3C00, 32'h0000_8000, 32'h0000_0001,
    32'h0000_7C00, 32'h0000_FC00, 32'h0000_7E01, 32'h0000_5BF8, 32'h0000_0080,
    32'h0000_007F, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0100_0001, 32'h0100_0003,
    32'h0000_0100, 32'h0000_0002, 32'h0000_00FF
  };

  logic [2:0] et;

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // reset type is fp32
    foreach (directed[i]) send(directed[i], 1'b0);
    for (int t = 1; t < 8; t++) begin
      write_type(3'(t));
      for (int i = 0; i < directed.size(); i += 3) send(directed[i], 1'b0);
    end
    for (int ph = 0; ph < 16; ph++) begin
      et = (ph < 12) ? 3'(ph % 6) : 3'($urandom_range(0, 7));
      write_type(et);
      for (int n = 0; n < 100; n++) begin
        send(rand_raw(et), (n / 25) % 2 == 0);
        if (n == 50) begin
          start_i <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
      end
    end
    start_i <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
